FILE: sv/lfc_pkg.sv
`timescale 1ns / 1ps
package lfc_pkg;

  localparam int unsigned HdrBytes = 20;
  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam int unsigned PayloadLimitDefault = 256;
  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    RegFirstMagic  = 3'd0,
    RegSecondMagic = 3'd1,
    RegVersion     = 3'd2,
    RegFlags       = 3'd3,
    RegHighState   = 3'd4,
    RegTypeMask    = 3'd5
  } lfc_reg_e;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StShort    = 4'd1,
    StMagic    = 4'd2,
    StVersion  = 4'd3,
    StType     = 4'd4,
    StFlags    = 4'd5,
    StState    = 4'd6,
    StTooLarge = 4'd7,
    StLength   = 4'd8,
    StSeqZero  = 4'd9,
    StCrc      = 4'd10
  } lfc_status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindStatus  = 1'b1
  } lfc_kind_e;

  typedef struct packed {
    logic [7:0]  first_magic;
    logic [7:0]  second_magic;
    logic [7:0]  protocol_version;
    logic [7:0]  required_flags;
    logic [7:0]  highest_state;
    logic [31:0] valid_type_mask;
  } lfc_cfg_t;

  // one queued request from the front: a payload byte or a frame end
  typedef struct packed {
    lfc_kind_e             kind;
    logic [7:0]            data;
    logic [PosW-1:0]       total;
    logic                  crc_ok;
    logic [19:0][7:0]      hdr;
  } lfc_item_t;

  typedef struct packed {
    lfc_kind_e   kind;
    logic [7:0]  payload_byte;
    lfc_status_e status;
    logic [7:0]  msg_code;
    logic [7:0]  frame_flags;
    logic [7:0]  peer_state;
    logic [15:0] body_len;
    logic [31:0] sequence_res;
    logic [31:0] origin_epoch;
    logic [31:0] sender_id;
  } lfc_result_t;

  // reflected crc-32, one byte, unrolled over eight bit steps
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: sv/lfc_front.sv
`timescale 1ns / 1ps
module lfc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 enq_o,
  output lfc_pkg::lfc_item_t   item_o
);

  logic [lfc_pkg::PosW-1:0] pos_q, pos_d, total;
  logic [31:0]              crc_q, crc_d, crc_upd;
  logic [31:0]              recent_q, recent_d, recent_upd;
  logic [19:0][7:0]         hdr_q, hdr_d;
  logic [15:0]              hdr_len;
  logic                     fwd;

  assign hdr_len    = {hdr_q[6], hdr_q[7]};
  assign total      = (pos_q != lfc_pkg::PosMax) ? pos_q + 1'b1 : lfc_pkg::PosMax;
  assign recent_upd = {recent_q[23:0], data_byte_i};
  // crc runs four bytes behind so the trailing crc bytes stay out of it
  assign crc_upd    = (pos_q >= lfc_pkg::PosW'(4)) ?
                      lfc_pkg::crc_byte(crc_q, recent_q[31:24]) : crc_q;
  assign fwd = (pos_q >= lfc_pkg::PosW'(lfc_pkg::HdrBytes)) &&
               (pos_q < ({1'b0, hdr_len} + lfc_pkg::PosW'(lfc_pkg::HdrBytes)));

  always_comb begin
    hdr_d = hdr_q;
    if (pos_q < lfc_pkg::PosW'(lfc_pkg::HdrBytes)) begin
      hdr_d[pos_q[4:0]] = data_byte_i;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    recent_d = recent_q;
    if (acc_i) begin
      if (last_byte_i) begin
        pos_d    = '0;
        crc_d    = lfc_pkg::CrcInit;
        recent_d = '0;
      end else begin
        pos_d    = total;
        crc_d    = crc_upd;
        recent_d = recent_upd;
      end
    end
  end

  always_comb begin
    enq_o         = acc_i && (last_byte_i || fwd);
    item_o.kind   = last_byte_i ? lfc_pkg::KindStatus : lfc_pkg::KindPayload;
    item_o.data   = data_byte_i;
    item_o.total  = total;
    item_o.crc_ok = (~crc_upd == recent_upd);
    item_o.hdr    = hdr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= lfc_pkg::CrcInit;
      recent_q <= '0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      recent_q <= recent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      hdr_q <= hdr_d;
    end
  end

`ifndef ASSERT_OFF
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && last_byte_i) |=> (pos_q == '0 && crc_q == lfc_pkg::CrcInit && recent_q == '0))
    else $error("frame state not cleared after last byte");
`endif

endmodule

FILE: sv/lfc_queue.sv
`timescale 1ns / 1ps
module lfc_queue #(
  parameter int unsigned DEPTH = lfc_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  lfc_pkg::lfc_item_t wr_item_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output logic               empty_o,
  output lfc_pkg::lfc_item_t rd_item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lfc_pkg::lfc_item_t mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> !full_o)
    else $error("request written into a full queue");
`endif

endmodule

FILE: sv/lfc_back.sv
`timescale 1ns / 1ps
module lfc_back #(
  parameter int unsigned PAYLOAD_LIMIT = lfc_pkg::PayloadLimitDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfc_pkg::lfc_cfg_t    cfg_i,
  input  logic                 q_empty_i,
  input  lfc_pkg::lfc_item_t   q_item_i,
  output logic                 q_rd_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output lfc_pkg::lfc_result_t res_o
);

  localparam logic [15:0] LimitW = 16'(PAYLOAD_LIMIT);
  localparam logic [lfc_pkg::PosW-1:0] MinTotal = lfc_pkg::PosW'(lfc_pkg::HdrBytes + 4);

  logic                 out_valid_q, out_valid_d;
  lfc_pkg::lfc_result_t out_q, res_d;
  lfc_pkg::lfc_status_e st;
  logic [19:0][7:0]     h;
  logic [15:0]          len;
  logic [31:0]          seq;
  logic                 load;

  assign h      = q_item_i.hdr;
  assign len    = {h[6], h[7]};
  assign seq    = {h[8], h[9], h[10], h[11]};
  assign load   = !q_empty_i && (!out_valid_q || pop_i);
  assign q_rd_o = load;

  // first failing check wins
  always_comb begin
    if (q_item_i.total < MinTotal) begin
      st = lfc_pkg::StShort;
    end else if (h[0] != cfg_i.first_magic || h[1] != cfg_i.second_magic) begin
      st = lfc_pkg::StMagic;
    end else if (h[2] != cfg_i.protocol_version) begin
      st = lfc_pkg::StVersion;
    end else if (h[3][7:5] != 3'd0 || !cfg_i.valid_type_mask[h[3][4:0]]) begin
      st = lfc_pkg::StType;
    end else if (h[4] != cfg_i.required_flags) begin
      st = lfc_pkg::StFlags;
    end else if (h[5] > cfg_i.highest_state) begin
      st = lfc_pkg::StState;
    end else if (len > LimitW) begin
      st = lfc_pkg::StTooLarge;
    end else if (q_item_i.total != ({1'b0, len} + MinTotal)) begin
      st = lfc_pkg::StLength;
    end else if (seq == '0) begin
      st = lfc_pkg::StSeqZero;
    end else if (!q_item_i.crc_ok) begin
      st = lfc_pkg::StCrc;
    end else begin
      st = lfc_pkg::StOk;
    end
  end

  always_comb begin
    res_d = '0;
    res_d.kind   = q_item_i.kind;
    res_d.status = lfc_pkg::StOk;
    case (q_item_i.kind)
      lfc_pkg::KindPayload: begin
        res_d.payload_byte = q_item_i.data;
      end
      lfc_pkg::KindStatus: begin
        res_d.status = st;
        if (st == lfc_pkg::StOk) begin
          res_d.msg_code     = h[3];
          res_d.frame_flags  = h[4];
          res_d.peer_state   = h[5];
          res_d.body_len     = len;
          res_d.sequence_res = seq;
          res_d.origin_epoch = {h[12], h[13], h[14], h[15]};
          res_d.sender_id    = {h[16], h[17], h[18], h[19]};
        end
      end
      default: begin
        res_d.kind = lfc_pkg::KindPayload;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

`ifndef ASSERT_OFF
  a_fields_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != lfc_pkg::StOk) |->
      (out_q.sequence_res == '0 && out_q.body_len == '0 && out_q.sender_id == '0))
    else $error("header fields not cleared on failing status");
  a_payload_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == lfc_pkg::KindPayload) |-> out_q.status == lfc_pkg::StOk)
    else $error("payload result carries a status");
`endif

endmodule

FILE: sv/link_frame_checker_crc32.sv
`timescale 1ns / 1ps
// a result goes into the queue, then into the output register that drives the output ports
// throughput: one byte per cycle, sustained while pop keeps up with results
// the front updates byte count and crc in the accept cycle; a 2-entry queue and an
// output register let the front keep taking bytes while a result waits to be popped
// reset (rst_ni low, asynchronous): count 0, crc all ones, queue and output empty,
// registers 0; header bytes are undefined until received
module link_frame_checker_crc32 #(
  parameter int unsigned PAYLOAD_LIMIT = lfc_pkg::PayloadLimitDefault,
  parameter int unsigned QUEUE_DEPTH   = lfc_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      result_kind_o,
  output logic [7:0]                payload_byte_o,
  output logic [3:0]                status_o,
  output logic [7:0]                msg_code_o,
  output logic [7:0]                frame_flags_o,
  output logic [7:0]                peer_state_o,
  output logic [15:0]               body_len_o,
  output logic [31:0]               sequence_res_o,
  output logic [31:0]               origin_epoch_o,
  output logic [31:0]               sender_id_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lfc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  lfc_pkg::lfc_cfg_t    cfg_q, cfg_d;
  lfc_pkg::lfc_reg_e    reg_idx;
  lfc_pkg::lfc_item_t   f_item, q_item;
  lfc_pkg::lfc_result_t res;
  logic                 acc, enq, q_full, q_empty, q_rd, wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = lfc_pkg::lfc_reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        lfc_pkg::RegFirstMagic:  cfg_d.first_magic      = pwdata[7:0];
        lfc_pkg::RegSecondMagic: cfg_d.second_magic     = pwdata[7:0];
        lfc_pkg::RegVersion:     cfg_d.protocol_version = pwdata[7:0];
        lfc_pkg::RegFlags:       cfg_d.required_flags   = pwdata[7:0];
        lfc_pkg::RegHighState:   cfg_d.highest_state    = pwdata[7:0];
        lfc_pkg::RegTypeMask:    cfg_d.valid_type_mask  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfc_pkg::RegFirstMagic:  prdata = {24'd0, cfg_q.first_magic};
      lfc_pkg::RegSecondMagic: prdata = {24'd0, cfg_q.second_magic};
      lfc_pkg::RegVersion:     prdata = {24'd0, cfg_q.protocol_version};
      lfc_pkg::RegFlags:       prdata = {24'd0, cfg_q.required_flags};
      lfc_pkg::RegHighState:   prdata = {24'd0, cfg_q.highest_state};
      lfc_pkg::RegTypeMask:    prdata = cfg_q.valid_type_mask;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // every byte is held off while the queue is full, result or not
  assign full = q_full;
  assign acc  = push && !q_full;

  lfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .enq_o       (enq),
    .item_o      (f_item)
  );

  lfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (enq),
    .wr_item_i (f_item),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .empty_o   (q_empty),
    .rd_item_o (q_item)
  );

  lfc_back #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign result_kind_o  = res.kind;
  assign payload_byte_o = res.payload_byte;
  assign status_o       = res.status;
  assign msg_code_o     = res.msg_code;
  assign frame_flags_o  = res.frame_flags;
  assign peer_state_o   = res.peer_state;
  assign body_len_o     = res.body_len;
  assign sequence_res_o = res.sequence_res;
  assign origin_epoch_o = res.origin_epoch;
  assign sender_id_o    = res.sender_id;

endmodule

FILE: tb/tb_link_frame_checker_crc32.sv
`timescale 1ns / 1ps
module tb_link_frame_checker_crc32;

  localparam int unsigned PayloadCap = lfc_pkg::PayloadLimitDefault;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 6;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic [7:0] data_byte_i;
  logic last_byte_i;
  logic empty;
  logic pop;
  logic result_kind_o;
  logic [7:0] payload_byte_o;
  logic [3:0] status_o;
  logic [7:0] msg_code_o;
  logic [7:0] frame_flags_o;
  logic [7:0] peer_state_o;
  logic [15:0] body_len_o;
  logic [31:0] sequence_res_o;
  logic [31:0] origin_epoch_o;
  logic [31:0] sender_id_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lfc_pkg::AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  link_frame_checker_crc32 #(
    .PAYLOAD_LIMIT(PayloadCap)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .empty(empty),
    .pop(pop),
    .result_kind_o(result_kind_o),
    .payload_byte_o(payload_byte_o),
    .status_o(status_o),
    .msg_code_o(msg_code_o),
    .frame_flags_o(frame_flags_o),
    .peer_state_o(peer_state_o),
    .body_len_o(body_len_o),
    .sequence_res_o(sequence_res_o),
    .origin_epoch_o(origin_epoch_o),
    .sender_id_o(sender_id_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // checker state as the link sees it
  lfc_pkg::lfc_cfg_t link_cfg;
  logic [lfc_pkg::PosW-1:0] byte_pos;
  logic [31:0] crc_acc;
  logic [7:0] hdr_bytes [lfc_pkg::HdrBytes];
  logic [31:0] tail_bytes;

  lfc_pkg::lfc_result_t frame_outputs_due [$];
  logic [7:0] frame_bytes [$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned hold_request;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] crc32_next(logic [31:0] acc, logic [7:0] d);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) begin
        r = (r >> 1) ^ lfc_pkg::CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] hdr_word(int unsigned at);
    return {hdr_bytes[at], hdr_bytes[at+1], hdr_bytes[at+2], hdr_bytes[at+3]};
  endfunction

  function automatic lfc_pkg::lfc_status_e judge_frame(int unsigned total);
    logic [7:0] t;
    int unsigned len;
    t = hdr_bytes[3];
    len = 32'({hdr_bytes[6], hdr_bytes[7]});
    if (total < lfc_pkg::HdrBytes + 4) return lfc_pkg::StShort;
    if (hdr_bytes[0] != link_cfg.first_magic || hdr_bytes[1] != link_cfg.second_magic) begin
      return lfc_pkg::StMagic;
    end
    if (hdr_bytes[2] != link_cfg.protocol_version) return lfc_pkg::StVersion;
    if (t >= 32 || !link_cfg.valid_type_mask[t[4:0]]) return lfc_pkg::StType;
    if (hdr_bytes[4] != link_cfg.required_flags) return lfc_pkg::StFlags;
    if (hdr_bytes[5] > link_cfg.highest_state) return lfc_pkg::StState;
    if (len > PayloadCap) return lfc_pkg::StTooLarge;
    if (total != lfc_pkg::HdrBytes + len + 4) return lfc_pkg::StLength;
    if (hdr_word(8) == 32'd0) return lfc_pkg::StSeqZero;
    if (~crc_acc != tail_bytes) return lfc_pkg::StCrc;
    return lfc_pkg::StOk;
  endfunction

  // advance the frame state by one accepted byte and queue what it produces
  task automatic follow_link_byte(input logic [7:0] b, input logic fin);
    int unsigned idx;
    int unsigned total;
    int unsigned len;
    lfc_pkg::lfc_result_t r;
    idx = 32'(byte_pos);
    if (idx < lfc_pkg::HdrBytes) hdr_bytes[idx] = b;
    // crc trails the input by four bytes
    if (idx >= 4) crc_acc = crc32_next(crc_acc, tail_bytes[31:24]);
    tail_bytes = {tail_bytes[23:0], b};
    total = (idx < 32'(lfc_pkg::PosMax)) ? idx + 1 : 32'(lfc_pkg::PosMax);
    byte_pos = lfc_pkg::PosW'(total);
    r = '0;
    if (fin) begin
      r.kind = lfc_pkg::KindStatus;
      r.status = judge_frame(total);
      if (r.status == lfc_pkg::StOk) begin
        r.msg_code = hdr_bytes[3];
        r.frame_flags = hdr_bytes[4];
        r.peer_state = hdr_bytes[5];
        r.body_len = {hdr_bytes[6], hdr_bytes[7]};
        r.sequence_res = hdr_word(8);
        r.origin_epoch = hdr_word(12);
        r.sender_id = hdr_word(16);
      end
      frame_outputs_due.push_back(r);
      byte_pos = '0;
      crc_acc = lfc_pkg::CrcInit;
      tail_bytes = '0;
    end else if (idx >= lfc_pkg::HdrBytes) begin
      len = 32'({hdr_bytes[6], hdr_bytes[7]});
      if (idx < lfc_pkg::HdrBytes + len) begin
        r.kind = lfc_pkg::KindPayload;
        r.payload_byte = b;
        frame_outputs_due.push_back(r);
      end
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  task automatic check_output();
    lfc_pkg::lfc_result_t want;
    if (frame_outputs_due.size() == 0) begin
      mismatches++;
      $display("%0t unexpected result expected none actual kind %0h status %0h",
               $time, result_kind_o, status_o);
    end else begin
      want = frame_outputs_due.pop_front();
      compare_field("result_kind", 32'(want.kind), 32'(result_kind_o));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
      compare_field("status", 32'(want.status), 32'(status_o));
      compare_field("msg_code", 32'(want.msg_code), 32'(msg_code_o));
      compare_field("frame_flags", 32'(want.frame_flags), 32'(frame_flags_o));
      compare_field("peer_state", 32'(want.peer_state), 32'(peer_state_o));
      compare_field("body_len", 32'(want.body_len), 32'(body_len_o));
      compare_field("sequence_res", want.sequence_res, sequence_res_o);
      compare_field("origin_epoch", want.origin_epoch, origin_epoch_o);
      compare_field("sender_id", want.sender_id, sender_id_o);
    end
  endtask

  // result side: own stall pattern, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    pop <= 1'b0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_output();
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= 1'($urandom_range(0, 1));
          end
          2: begin
            pop <= (mode_left % 4 == 0);
          end
          default: begin
            pop <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    follow_link_byte(b, fin);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_bytes.size(); k++) begin
      send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    end
  endtask

  // stop sending and wait for every queued result plus the pipeline tail
  task automatic settle_outputs();
    push <= 1'b0;
    burst_left = 0;
    while (frame_outputs_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input lfc_pkg::lfc_reg_e r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      lfc_pkg::RegFirstMagic: begin
        link_cfg.first_magic = v[7:0];
      end
      lfc_pkg::RegSecondMagic: begin
        link_cfg.second_magic = v[7:0];
      end
      lfc_pkg::RegVersion: begin
        link_cfg.protocol_version = v[7:0];
      end
      lfc_pkg::RegFlags: begin
        link_cfg.required_flags = v[7:0];
      end
      lfc_pkg::RegHighState: begin
        link_cfg.highest_state = v[7:0];
      end
      default: begin
        link_cfg.valid_type_mask = v;
      end
    endcase
  endtask

  task automatic apply_config(input lfc_pkg::lfc_cfg_t c);
    settle_outputs();
    write_reg(lfc_pkg::RegFirstMagic, {24'd0, c.first_magic});
    write_reg(lfc_pkg::RegSecondMagic, {24'd0, c.second_magic});
    write_reg(lfc_pkg::RegVersion, {24'd0, c.protocol_version});
    write_reg(lfc_pkg::RegFlags, {24'd0, c.required_flags});
    write_reg(lfc_pkg::RegHighState, {24'd0, c.highest_state});
    write_reg(lfc_pkg::RegTypeMask, c.valid_type_mask);
  endtask

  function automatic lfc_pkg::lfc_cfg_t random_cfg();
    lfc_pkg::lfc_cfg_t c;
    c.first_magic = 8'($urandom);
    c.second_magic = 8'($urandom);
    c.protocol_version = 8'($urandom);
    c.required_flags = 8'($urandom);
    case ($urandom_range(0, 3))
      0: c.highest_state = 8'h00;
      1: c.highest_state = 8'hFF;
      default: c.highest_state = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: c.valid_type_mask = '0;
      1: c.valid_type_mask = '1;
      2: c.valid_type_mask = 32'd1 << $urandom_range(0, 31);
      default: c.valid_type_mask = $urandom;
    endcase
    return c;
  endfunction

  // rewrite the trailing four bytes with the crc of everything before them
  task automatic seal_frame();
    logic [31:0] c;
    int unsigned n;
    n = frame_bytes.size();
    c = lfc_pkg::CrcInit;
    for (int k = 0; k < n - 4; k++) c = crc32_next(c, frame_bytes[k]);
    c = ~c;
    frame_bytes[n-4] = c[31:24];
    frame_bytes[n-3] = c[23:16];
    frame_bytes[n-2] = c[15:8];
    frame_bytes[n-1] = c[7:0];
  endtask

  // build a frame that passes every check but the one named by fault
  task automatic make_frame(input int unsigned plen, input lfc_pkg::lfc_status_e fault);
    logic [7:0] m0, m1, ver, mtype, flg, nstate;
    logic [15:0] len_field;
    logic [31:0] seq, epoch, sid;
    int unsigned keep;
    int unsigned k;
    m0 = link_cfg.first_magic;
    m1 = link_cfg.second_magic;
    ver = link_cfg.protocol_version;
    flg = link_cfg.required_flags;
    nstate = 8'($urandom_range(0, link_cfg.highest_state));
    mtype = 8'($urandom_range(0, 31));
    if (link_cfg.valid_type_mask != '0) begin
      while (!link_cfg.valid_type_mask[mtype[4:0]]) mtype = 8'($urandom_range(0, 31));
    end
    seq = $urandom;
    if (seq == 32'd0) seq = 32'd1;
    epoch = $urandom;
    sid = $urandom;
    len_field = 16'(plen);
    case (fault)
      lfc_pkg::StMagic: begin
        if ($urandom_range(0, 1) == 1) begin
          m0 = m0 ^ 8'($urandom_range(1, 255));
        end else begin
          m1 = m1 ^ 8'($urandom_range(1, 255));
        end
      end
      lfc_pkg::StVersion: begin
        ver = ver ^ 8'($urandom_range(1, 255));
      end
      lfc_pkg::StType: begin
        if (link_cfg.valid_type_mask != '1 && $urandom_range(0, 1) == 1) begin
          while (link_cfg.valid_type_mask[mtype[4:0]]) mtype = 8'($urandom_range(0, 31));
        end else begin
          mtype = 8'($urandom_range(32, 255));
        end
      end
      lfc_pkg::StFlags: begin
        flg = flg ^ 8'($urandom_range(1, 255));
      end
      lfc_pkg::StState: begin
        if (link_cfg.highest_state != 8'hFF) begin
          nstate = 8'($urandom_range(int'(link_cfg.highest_state) + 1, 255));
        end
      end
      lfc_pkg::StTooLarge: begin
        len_field = 16'($urandom_range(PayloadCap + 1, 65535));
      end
      lfc_pkg::StLength: begin
        len_field = (plen < PayloadCap) ? 16'(plen + 1) : 16'(plen - 1);
      end
      lfc_pkg::StSeqZero: begin
        seq = '0;
      end
      default: begin
      end
    endcase
    frame_bytes.delete();
    frame_bytes.push_back(m0);
    frame_bytes.push_back(m1);
    frame_bytes.push_back(ver);
    frame_bytes.push_back(mtype);
    frame_bytes.push_back(flg);
    frame_bytes.push_back(nstate);
    frame_bytes.push_back(len_field[15:8]);
    frame_bytes.push_back(len_field[7:0]);
    for (int j = 3; j >= 0; j--) frame_bytes.push_back(seq[8*j +: 8]);
    for (int j = 3; j >= 0; j--) frame_bytes.push_back(epoch[8*j +: 8]);
    for (int j = 3; j >= 0; j--) frame_bytes.push_back(sid[8*j +: 8]);
    repeat (plen) frame_bytes.push_back(8'($urandom));
    repeat (4) frame_bytes.push_back(8'h00);
    seal_frame();
    if (fault == lfc_pkg::StCrc) begin
      k = frame_bytes.size() - 1 - $urandom_range(0, 3);
      frame_bytes[k] = frame_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (fault == lfc_pkg::StShort) begin
      keep = $urandom_range(1, lfc_pkg::HdrBytes + 3);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic test_good_frames();
    lfc_pkg::lfc_cfg_t c;
    c.first_magic = 8'hC3;
    c.second_magic = 8'h3C;
    c.protocol_version = 8'h02;
    c.required_flags = 8'h81;
    c.highest_state = 8'h04;
    c.valid_type_mask = 32'h8000_00A5;
    apply_config(c);
    make_frame(0, lfc_pkg::StOk);
    send_frame();
    make_frame(7, lfc_pkg::StOk);
    send_frame();
    // largest payload, top type, top state, all-ones sequence
    make_frame(PayloadCap, lfc_pkg::StOk);
    frame_bytes[3] = 8'd31;
    frame_bytes[5] = link_cfg.highest_state;
    for (int k = 8; k < 12; k++) frame_bytes[k] = 8'hFF;
    seal_frame();
    send_frame();
  endtask

  task automatic test_each_status();
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom));
    send_frame();
    for (int f = int'(lfc_pkg::StShort); f <= int'(lfc_pkg::StCrc); f++) begin
      make_frame(3, lfc_pkg::lfc_status_e'(f));
      send_frame();
    end
    // frame ends on a payload byte
    make_frame(10, lfc_pkg::StOk);
    while (frame_bytes.size() > lfc_pkg::HdrBytes + 5) void'(frame_bytes.pop_back());
    send_frame();
  endtask

  task automatic test_register_extremes();
    lfc_pkg::lfc_cfg_t c;
    c = '0;
    c.valid_type_mask = 32'd1;
    apply_config(c);
    make_frame(2, lfc_pkg::StOk);
    send_frame();
    make_frame(2, lfc_pkg::StState);
    send_frame();
    c.first_magic = 8'hFF;
    c.second_magic = 8'hFF;
    c.protocol_version = 8'hFF;
    c.required_flags = 8'hFF;
    c.highest_state = 8'hFF;
    c.valid_type_mask = '1;
    apply_config(c);
    make_frame(2, lfc_pkg::StOk);
    send_frame();
    make_frame(2, lfc_pkg::StType);
    send_frame();
    make_frame(1, lfc_pkg::StFlags);
    send_frame();
  endtask

  task automatic test_backpressure();
    apply_config(random_cfg());
    hold_request = HoldCycles;
    make_frame(120, lfc_pkg::StOk);
    send_frame();
    settle_outputs();
  endtask

  // frame runs far past its declared length before the last byte
  task automatic test_overlong_frame();
    make_frame(4, lfc_pkg::StOk);
    repeat (200) frame_bytes.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned plen;
    int unsigned cut;
    int unsigned target;
    for (int ph = 0; ph < 4; ph++) begin
      apply_config(random_cfg());
      target = bytes_sent + 250;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, PayloadCap)
                                            : $urandom_range(0, 12);
        if (pick < 70) begin
          if ($urandom_range(0, 1) == 1) begin
            make_frame(plen, lfc_pkg::StOk);
          end else begin
            make_frame(plen, lfc_pkg::lfc_status_e'($urandom_range(int'(lfc_pkg::StShort),
                                                                   int'(lfc_pkg::StCrc))));
          end
        end else if (pick < 85) begin
          make_frame(plen, lfc_pkg::StOk);
          cut = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end else begin
          frame_bytes.delete();
          repeat ($urandom_range(1, 48)) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    data_byte_i <= 8'h00;
    last_byte_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    link_cfg = '0;
    byte_pos = '0;
    crc_acc = lfc_pkg::CrcInit;
    tail_bytes = '0;
    for (int k = 0; k < lfc_pkg::HdrBytes; k++) hdr_bytes[k] = 8'h00;
    mismatches = 0;
    bytes_sent = 0;
    burst_left = 0;
    hold_request = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_frames();
    test_each_status();
    test_register_extremes();
    test_backpressure();
    test_overlong_frame();
    test_random_traffic();

    settle_outputs();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && frame_outputs_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
